/* hw/rtl/http_chunk_parser_defines.svh */
// ----------------------------------------------------------------------------
// HTTP chunk parser assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNK_PARSER_DEFINES_SVH
`define HTTP_CHUNK_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a property holds on every clock edge outside reset.
`define HCP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an expression never holds outside reset.
`define HCP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define HCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define HCP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* hw/rtl/hcp_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP chunk parser package
// Item types, parser state codes, character constants and byte classifiers.
// ----------------------------------------------------------------------------
`default_nettype none

package hcp_pkg;

    // Item kinds
    localparam logic KIND_FEED    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Parser state codes
    localparam logic [2:0] ST_SIZE  = 3'd0;
    localparam logic [2:0] ST_EXT   = 3'd1;
    localparam logic [2:0] ST_CRLF  = 3'd2;
    localparam logic [2:0] ST_DATA  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_ERROR = 3'd5;

    // Which state a CR LF pair was entered from
    localparam logic [1:0] RET_SIZE = 2'd0;
    localparam logic [1:0] RET_EXT  = 2'd1;
    localparam logic [1:0] RET_DATA = 2'd2;

    // Characters
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF_A = 8'h66;
    localparam logic [7:0] CH_LZ   = 8'h7A;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_UZ   = 8'h5A;
    localparam logic [3:0] HEX_TEN = 4'd10;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } hcp_in_t;

    typedef struct packed {
        logic       payload_valid;
        logic [2:0] status;
        logic       last_chunk;
    } hcp_out_t;

    typedef struct packed {
        logic [2:0] parse_state;
        logic [1:0] return_state;
        logic       size_seen;
        logic       zero_size;
    } hcp_ctrl_t;

    localparam hcp_ctrl_t CTRL_RESET = '{
        parse_state:  ST_SIZE,
        return_state: RET_SIZE,
        size_seen:    1'b0,
        zero_size:    1'b0
    };

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
               ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LF_A)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if ((c >= CH_0) && (c <= CH_9)) begin
            d = c - CH_0;
        end else if ((c >= CH_LA) && (c <= CH_LF_A)) begin
            d = c - CH_LA + {4'd0, HEX_TEN};
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            d = c - CH_UA + {4'd0, HEX_TEN};
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hcp_step.sv */
// ----------------------------------------------------------------------------
// HTTP chunk parser step logic
// Next parser state and result for one item, from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module hcp_step #(
    parameter int SIZE_BITS = 32
) (
    input  hcp_pkg::hcp_in_t       item,
    input  hcp_pkg::hcp_ctrl_t     ctrl,
    input  logic [SIZE_BITS-1:0]   size_cur,
    input  logic [SIZE_BITS-1:0]   count_cur,
    output hcp_pkg::hcp_ctrl_t     ctrl_next,
    output logic [SIZE_BITS-1:0]   size_next,
    output logic [SIZE_BITS-1:0]   count_next,
    output hcp_pkg::hcp_out_t      result
);
    import hcp_pkg::*;

    logic                 keep;
    logic                 size_ovf;
    logic [SIZE_BITS-1:0] size_shifted;
    logic [7:0]           c;

    assign c            = item.in_byte;
    // A new digit overflows exactly when the top nibble is already in use.
    assign size_ovf     = |size_cur[SIZE_BITS-1 -: 4];
    assign size_shifted = {size_cur[SIZE_BITS-5:0], hex_val(c)};

    always_comb begin
        ctrl_next  = ctrl;
        size_next  = size_cur;
        count_next = count_cur;
        keep       = 1'b0;
        if (item.kind == KIND_RESTART) begin
            ctrl_next  = CTRL_RESET;
            size_next  = '0;
            count_next = '0;
        end else begin
            unique case (ctrl.parse_state)
                ST_SIZE: begin
                    priority if (is_alnum(c)) begin
                        if (!is_hex(c) || size_ovf) begin
                            ctrl_next.parse_state = ST_ERROR;
                        end else begin
                            size_next           = size_shifted;
                            ctrl_next.size_seen = 1'b1;
                            if (size_shifted == '0) begin
                                ctrl_next.zero_size = 1'b1;
                            end
                        end
                    end else if (c == CH_SEMI) begin
                        ctrl_next.parse_state = ST_EXT;
                    end else if ((c == CH_CR) && ctrl.size_seen) begin
                        ctrl_next.return_state = RET_SIZE;
                        ctrl_next.parse_state  = ST_CRLF;
                    end else begin
                        ctrl_next.parse_state = ST_ERROR;
                    end
                end
                ST_EXT: begin
                    if (c == CH_CR) begin
                        ctrl_next.return_state = RET_EXT;
                        ctrl_next.parse_state  = ST_CRLF;
                    end
                end
                ST_CRLF: begin
                    if (c != CH_LF) begin
                        ctrl_next.parse_state = ST_ERROR;
                    end else if ((ctrl.return_state == RET_SIZE) ||
                                 (ctrl.return_state == RET_EXT)) begin
                        ctrl_next.parse_state = ST_DATA;
                    end else if (ctrl.return_state == RET_DATA) begin
                        ctrl_next.parse_state = ST_DONE;
                    end else begin
                        ctrl_next.parse_state = ST_ERROR;
                    end
                end
                ST_DATA: begin
                    priority if (count_cur < size_cur) begin
                        keep       = 1'b1;
                        count_next = count_cur + SIZE_BITS'(1);
                    end else if (c == CH_CR) begin
                        ctrl_next.return_state = RET_DATA;
                        ctrl_next.parse_state  = ST_CRLF;
                    end else begin
                        ctrl_next.parse_state = ST_ERROR;
                    end
                end
                ST_DONE: begin
                    ctrl_next = ctrl;
                end
                default: begin
                    ctrl_next.parse_state = ST_ERROR;
                end
            endcase
        end
    end

    assign result = '{
        payload_valid: keep,
        status:        ctrl_next.parse_state,
        last_chunk:    ctrl_next.zero_size
    };

endmodule

`default_nettype wire

/* hw/rtl/http_chunk_parser.sv */
// ----------------------------------------------------------------------------
// HTTP chunk parser
// Byte-serial decoder for one chunk of an HTTP chunked body.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                        | Moves
//   --------+------------------------------+------------------------------------
//   input   | s_valid, s_ready, s_item     | one byte or a restart per item
//   result  | m_valid, m_ready, m_item     | payload flag, status, last chunk
//
// Throughput is one item per cycle while m_ready stays high; an accepted item
// passes the input register, then the result register, on its way to m_item.
// The loop from the parser state registers through hcp_step and back sets
// the cycle time; it holds a SIZE_BITS compare, a zero test and an increment.
// Reset (aresetn low, synchronous) puts the parser in the size state with a
// zero size and count, and empties both registers.
// While m_ready is low a held result stays in the result register; the input register still
// takes one more item, then s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "http_chunk_parser_defines.svh"

module http_chunk_parser #(
    parameter int SIZE_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hcp_pkg::hcp_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output hcp_pkg::hcp_out_t m_item
);
    import hcp_pkg::*;

    // Input register
    logic                 in_valid_reg;
    hcp_in_t              in_item_reg;
    // Result register
    logic                 out_valid_reg;
    hcp_out_t             out_item_reg;
    // Parser state
    hcp_ctrl_t            ctrl_reg;
    hcp_ctrl_t            ctrl_next;
    logic [SIZE_BITS-1:0] size_reg;
    logic [SIZE_BITS-1:0] size_next;
    logic [SIZE_BITS-1:0] count_reg;
    logic [SIZE_BITS-1:0] count_next;
    hcp_out_t             result;

    logic s_take;
    logic advance;

    // Terms for the checks at the end
    logic restart_adv;
    logic payload_out;
    logic data_out;
    logic zero_hold;
    logic done_now;
    logic done_hold;

    // Advance the held item into the result register when that slot is free
    // or being emptied this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    hcp_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .item       (in_item_reg),
        .ctrl       (ctrl_reg),
        .size_cur   (size_reg),
        .count_cur  (count_reg),
        .ctrl_next  (ctrl_next),
        .size_next  (size_next),
        .count_next (count_next),
        .result     (result)
    );

    // Control and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= CTRL_RESET;
            size_reg      <= '0;
            count_reg     <= '0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                ctrl_reg      <= ctrl_next;
                size_reg      <= size_next;
                count_reg     <= count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on handshake or advance, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign restart_adv = advance && (in_item_reg.kind == KIND_RESTART);
    assign payload_out = out_valid_reg && out_item_reg.payload_valid;
    assign data_out    = (out_item_reg.status == ST_DATA);
    assign zero_hold   = ctrl_reg.zero_size && !restart_adv;
    assign done_now    = (ctrl_reg.parse_state == ST_DONE);
    assign done_hold   = done_now && !restart_adv;

    // Payload bytes only come out of the data state.
    `HCP_ASSERT(a_payload_in_data, aclk, aresetn, payload_out |-> data_out, "payload outside data")
    // The data counter never passes the declared size.
    `HCP_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > size_reg, "count beyond size")
    // The last-chunk flag stays set until a restart.
    `HCP_ASSERT(a_zero_sticky, aclk, aresetn, zero_hold |=> ctrl_reg.zero_size, "last flag dropped")
    // Done holds until a restart.
    `HCP_ASSERT(a_done_holds, aclk, aresetn, done_hold |=> done_now, "done left early")

endmodule

`default_nettype wire
